// ----- rtl/core/lavm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and fixed widths for the view basis pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

  typedef logic signed [31:0] word_t;

  localparam int MW       = 30;          // normalized magnitude width
  localparam int SW       = 2 * MW + 2;  // sum of three squares
  localparam int RW       = 31;          // square root width
  localparam int QW       = 31;          // quotient width
  localparam int NUM_W    = 2 * MW + 1;  // dividend width
  localparam int NORM_LAT = 70;
  localparam int CROSS_LAT = 2;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

endpackage

// ----- rtl/core/lavm_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer to Q2.30: prescale, sum of squares,
// one-bit-per-stage square root, one-bit-per-stage divide, sign restore.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int VW = 33,
  parameter int PW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [VW-1:0] vec_i [3],
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output lavm_pkg::word_t      unit_o [3],
  output logic [PW-1:0]        pay_o
);
  import lavm_pkg::*;

  localparam int BW = $clog2(VW + 1);
  localparam logic [BW-1:0] MWB = BW'(MW);

  logic [PW+2:0]         line_q [NORM_LAT];
  logic [NORM_LAT-1:0]   vld_q;

  logic [VW-1:0] mag1_q [3];
  logic [VW-1:0] mag2_q [3];
  logic [VW-1:0] mx2_q;
  logic [VW-1:0] mag3_q [3];
  logic [BW-1:0] bits3_q;
  logic [BW-1:0] bits_d;
  logic [MW-1:0] nm4_q [3];
  logic [MW-1:0] nm5_q [3];
  logic [2*MW-1:0] sq5_q [3];

  logic [RW+2:0] rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [SW-1:0] rad_q  [RW+1];
  logic [MW-1:0] nms_q  [RW+1][3];
  logic [RW+2:0] rem2_w [RW+1];
  logic [RW+2:0] trial_w [RW+1];

  logic [RW-1:0] rr_q [QW+1][3];
  logic [QW-1:0] nb_q [QW+1][3];
  logic [QW-1:0] qq_q [QW+1][3];
  logic [RW-1:0] dl_q [QW+1];
  logic [RW:0]   r2_w [QW+1][3];

  logic [NUM_W-1:0] num_w [3];
  word_t out_q [3];
  logic [2:0] neg_w;
  logic [RW-1:0] root_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NORM_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    line_q[0] <= {vec_i[2][VW-1], vec_i[1][VW-1], vec_i[0][VW-1], pay_i};
    for (int k = 1; k < NORM_LAT; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  always_comb begin
    bits_d = '0;
    for (int j = 0; j < VW; j++) begin
      if (mx2_q[j]) begin
        bits_d = BW'(j + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag1_q[i] <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
      mag2_q[i] <= mag1_q[i];
      mag3_q[i] <= mag2_q[i];
      nm4_q[i]  <= (bits3_q > MWB) ? MW'(mag3_q[i] >> (bits3_q - MWB))
                                   : (mag3_q[i][MW-1:0] << (MWB - bits3_q));
      sq5_q[i]  <= nm4_q[i] * nm4_q[i];
      nm5_q[i]  <= nm4_q[i];
    end
    mx2_q   <= (mag1_q[0] > mag1_q[1]) ?
               ((mag1_q[0] > mag1_q[2]) ? mag1_q[0] : mag1_q[2]) :
               ((mag1_q[1] > mag1_q[2]) ? mag1_q[1] : mag1_q[2]);
    bits3_q <= bits_d;
  end

  always_comb begin
    rem2_w[0]  = '0;
    trial_w[0] = '0;
    for (int k = 1; k <= RW; k++) begin
      rem2_w[k]  = {rem_q[k-1][RW:0], rad_q[k-1][SW-1 -: 2]};
      trial_w[k] = {1'b0, root_q[k-1], 2'b01};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= SW'(sq5_q[0]) + SW'(sq5_q[1]) + SW'(sq5_q[2]);
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    for (int i = 0; i < 3; i++) begin
      nms_q[0][i] <= nm5_q[i];
    end
    for (int k = 1; k <= RW; k++) begin
      rad_q[k] <= rad_q[k-1] << 2;
      if (rem2_w[k] >= trial_w[k]) begin
        rem_q[k]  <= rem2_w[k] - trial_w[k];
        root_q[k] <= {root_q[k-1][RW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem2_w[k];
        root_q[k] <= {root_q[k-1][RW-2:0], 1'b0};
      end
      for (int i = 0; i < 3; i++) begin
        nms_q[k][i] <= nms_q[k-1][i];
      end
    end
  end

  assign root_end = root_q[RW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_w[i] = {1'b0, nms_q[RW][i], {MW{1'b0}}} + NUM_W'(root_end >> 1);
    end
    for (int i = 0; i < 3; i++) begin
      r2_w[0][i] = '0;
    end
    for (int k = 1; k <= QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        r2_w[k][i] = {rr_q[k-1][i], nb_q[k-1][i][QW-1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q[0] <= root_end;
    for (int i = 0; i < 3; i++) begin
      rr_q[0][i] <= RW'(num_w[i][NUM_W-1:QW]);
      nb_q[0][i] <= num_w[i][QW-1:0];
      qq_q[0][i] <= '0;
    end
    for (int k = 1; k <= QW; k++) begin
      dl_q[k] <= dl_q[k-1];
      for (int i = 0; i < 3; i++) begin
        nb_q[k][i] <= nb_q[k-1][i] << 1;
        if (r2_w[k][i] >= {1'b0, dl_q[k-1]}) begin
          rr_q[k][i] <= RW'(r2_w[k][i] - {1'b0, dl_q[k-1]});
          qq_q[k][i] <= {qq_q[k-1][i][QW-2:0], 1'b1};
        end else begin
          rr_q[k][i] <= RW'(r2_w[k][i]);
          qq_q[k][i] <= {qq_q[k-1][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign neg_w = line_q[NORM_LAT-2][PW+2:PW];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dl_q[QW] == '0) begin
        out_q[i] <= '0;
      end else if (neg_w[i]) begin
        out_q[i] <= -$signed({1'b0, qq_q[QW][i]});
      end else begin
        out_q[i] <= $signed({1'b0, qq_q[QW][i]});
      end
    end
  end

  assign valid_o = vld_q[NORM_LAT-1];
  assign pay_o   = line_q[NORM_LAT-1][PW-1:0];
  assign unit_o  = out_q;

endmodule

// ----- rtl/core/lavm_cross.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_cross
// Two-stage cross product: six registered products, then differences.
// ----------------------------------------------------------------------------
module lavm_cross #(
  parameter int PW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lavm_pkg::word_t    a_i [3],
  input  lavm_pkg::word_t    b_i [3],
  input  logic [PW-1:0]      pay_i,
  output logic               valid_o,
  output logic signed [63:0] c_o [3],
  output logic [PW-1:0]      pay_o
);
  import lavm_pkg::*;

  logic signed [63:0] p_q [6];
  logic signed [63:0] c_q [3];
  logic [PW-1:0]      pay_q [CROSS_LAT];
  logic [CROSS_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CROSS_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= a_i[1] * b_i[2];
    p_q[1] <= a_i[2] * b_i[1];
    p_q[2] <= a_i[2] * b_i[0];
    p_q[3] <= a_i[0] * b_i[2];
    p_q[4] <= a_i[0] * b_i[1];
    p_q[5] <= a_i[1] * b_i[0];
    c_q[0] <= p_q[0] - p_q[1];
    c_q[1] <= p_q[2] - p_q[3];
    c_q[2] <= p_q[4] - p_q[5];
    pay_q[0] <= pay_i;
    for (int k = 1; k < CROSS_LAT; k++) begin
      pay_q[k] <= pay_q[k-1];
    end
  end

  assign valid_o = vld_q[CROSS_LAT-1];
  assign c_o     = c_q;
  assign pay_o   = pay_q[CROSS_LAT-1];

endmodule

// ----- rtl/core/look_at_view_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point camera view basis: side, true up, back (Q2.30), shift (Q16.16).
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle, busy_o is always low, and each
// result appears with done_o high for one cycle.
// The depth comes from the two normalizers, each with a 31-stage square root
// and a 31-stage divider at one bit per stage, plus two cross product units.
// The receiver cannot stall, so nothing is ever held back.
module look_at_view_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  lavm_pkg::word_t eye_x_i,
  input  lavm_pkg::word_t eye_y_i,
  input  lavm_pkg::word_t eye_z_i,
  input  lavm_pkg::word_t target_x_i,
  input  lavm_pkg::word_t target_y_i,
  input  lavm_pkg::word_t target_z_i,
  input  lavm_pkg::word_t upward_x_i,
  input  lavm_pkg::word_t upward_y_i,
  input  lavm_pkg::word_t upward_z_i,
  output logic            done_o,
  output lavm_pkg::word_t side_x_o,
  output lavm_pkg::word_t side_y_o,
  output lavm_pkg::word_t side_z_o,
  output lavm_pkg::word_t true_up_x_o,
  output lavm_pkg::word_t true_up_y_o,
  output lavm_pkg::word_t true_up_z_o,
  output lavm_pkg::word_t back_x_o,
  output lavm_pkg::word_t back_y_o,
  output lavm_pkg::word_t back_z_o,
  output lavm_pkg::word_t shift_x_o,
  output lavm_pkg::word_t shift_y_o,
  output lavm_pkg::word_t shift_z_o
);
  import lavm_pkg::*;

  word_t eye_w [3];
  word_t tgt_w [3];
  word_t upw_w [3];

  logic               v0_q;
  logic signed [32:0] fwd0_q [3];
  word_t              up0_q [3];
  word_t              sh0_q [3];

  logic        nf_vld;
  word_t       f_w [3];
  logic [191:0] nf_pay;
  word_t       upf_w [3];
  word_t       shf_w [3];

  logic               cs_vld;
  logic signed [63:0] sraw_w [3];
  logic [191:0]       cs_pay;

  logic        ns_vld;
  word_t       s_w [3];
  logic [191:0] ns_pay;
  word_t       fs_w [3];

  logic               cu_vld;
  logic signed [63:0] d_w [3];
  logic [287:0]       cu_pay;
  word_t              su_w [3];
  word_t              fu_w [3];
  word_t              shu_w [3];

  logic signed [63:0] t_w [3];
  logic signed [33:0] r_w [3];
  word_t              u_w [3];

  logic  done_q;
  word_t side_q [3];
  word_t up_q [3];
  word_t back_q [3];
  word_t shift_q [3];

  assign eye_w = '{eye_x_i, eye_y_i, eye_z_i};
  assign tgt_w = '{target_x_i, target_y_i, target_z_i};
  assign upw_w = '{upward_x_i, upward_y_i, upward_z_i};

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start_i;
      done_q <= cu_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      fwd0_q[i] <= 33'(tgt_w[i]) - 33'(eye_w[i]);
      up0_q[i]  <= upw_w[i];
      sh0_q[i]  <= (eye_w[i] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -eye_w[i];
    end
  end

  lavm_norm #(.VW(33), .PW(192)) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vec_i   (fwd0_q),
    .pay_i   ({up0_q[2], up0_q[1], up0_q[0], sh0_q[2], sh0_q[1], sh0_q[0]}),
    .valid_o (nf_vld),
    .unit_o  (f_w),
    .pay_o   (nf_pay)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upf_w[i] = $signed(nf_pay[96 + 32*i +: 32]);
      shf_w[i] = $signed(nf_pay[32*i +: 32]);
    end
  end

  lavm_cross #(.PW(192)) u_cross_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nf_vld),
    .a_i     (f_w),
    .b_i     (upf_w),
    .pay_i   ({f_w[2], f_w[1], f_w[0], shf_w[2], shf_w[1], shf_w[0]}),
    .valid_o (cs_vld),
    .c_o     (sraw_w),
    .pay_o   (cs_pay)
  );

  lavm_norm #(.VW(64), .PW(192)) u_norm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cs_vld),
    .vec_i   (sraw_w),
    .pay_i   (cs_pay),
    .valid_o (ns_vld),
    .unit_o  (s_w),
    .pay_o   (ns_pay)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fs_w[i] = $signed(ns_pay[96 + 32*i +: 32]);
    end
  end

  lavm_cross #(.PW(288)) u_cross_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ns_vld),
    .a_i     (s_w),
    .b_i     (fs_w),
    .pay_i   ({s_w[2], s_w[1], s_w[0], ns_pay}),
    .valid_o (cu_vld),
    .c_o     (d_w),
    .pay_o   (cu_pay)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      su_w[i]  = $signed(cu_pay[192 + 32*i +: 32]);
      fu_w[i]  = $signed(cu_pay[96 + 32*i +: 32]);
      shu_w[i] = $signed(cu_pay[32*i +: 32]);
      t_w[i]   = d_w[i] + HALF_Q30;
      r_w[i]   = t_w[i][63:30];
      if (r_w[i][33:31] == 3'b000 || r_w[i][33:31] == 3'b111) begin
        u_w[i] = r_w[i][31:0];
      end else if (r_w[i][33]) begin
        u_w[i] = 32'sh8000_0000;
      end else begin
        u_w[i] = 32'sh7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      side_q[i]  <= su_w[i];
      up_q[i]    <= u_w[i];
      back_q[i]  <= -fu_w[i];
      shift_q[i] <= shu_w[i];
    end
  end

  assign done_o      = done_q;
  assign side_x_o    = side_q[0];
  assign side_y_o    = side_q[1];
  assign side_z_o    = side_q[2];
  assign true_up_x_o = up_q[0];
  assign true_up_y_o = up_q[1];
  assign true_up_z_o = up_q[2];
  assign back_x_o    = back_q[0];
  assign back_y_o    = back_q[1];
  assign back_z_o    = back_q[2];
  assign shift_x_o   = shift_q[0];
  assign shift_y_o   = shift_q[1];
  assign shift_z_o   = shift_q[2];

endmodule

// ----- sim/look_at_view_matrix_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_tb
// Streams eye, target and upward points through the view basis block and
// compares every side, true up, back and shift result against a bit-exact
// fixed-point prediction, with random input gaps and a drain pause.
// ----------------------------------------------------------------------------
module look_at_view_matrix_tb;
  import lavm_pkg::*;

  localparam int NUM_ITEMS   = 1350;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_OUT     = 12;

  typedef struct {
    word_t eye[3];
    word_t tgt[3];
    word_t upw[3];
  } view_in_t;

  typedef struct {
    word_t w[NUM_OUT];
  } basis_t;

  class basis_scoreboard;
    basis_t  expected_q[$];
    int      mismatches;
    int      checked;
    string   names[NUM_OUT] = '{"side_x", "side_y", "side_z", "true_up_x", "true_up_y",
                                "true_up_z", "back_x", "back_y", "back_z", "shift_x",
                                "shift_y", "shift_z"};

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic void unit_vec(input longint v[3], output longint n[3]);
      logic [63:0] mag[3];
      logic [63:0] mx;
      logic [63:0] sum;
      logic [63:0] len;
      logic [63:0] q;
      bit          neg[3];
      int          bits;
      mx = 0;
      bits = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? 64'd0 - v[i] : v[i];
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
        n = '{0, 0, 0};
        return;
      end
      while (bits < 64 && (mx >> bits) != 0) bits++;
      for (int i = 0; i < 3; i++)
        mag[i] = (bits > 30) ? mag[i] >> (bits - 30) : mag[i] << (30 - bits);
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 30) + (len >> 1)) / len;
        n[i] = neg[i] ? -longint'(q) : longint'(q);
      end
    endfunction

    function automatic longint round_q30(longint x);
      logic [63:0] b;
      longint      r;
      b = x + (64'd1 << 29) + (64'd1 << 62);
      r = longint'(b >> 30) - (64'sd1 <<< 32);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function automatic basis_t view_basis(view_in_t t);
      longint eye[3], fwd[3], up[3], f[3], sr[3], s[3], sh;
      basis_t b;
      for (int i = 0; i < 3; i++) begin
        eye[i] = longint'(t.eye[i]);
        fwd[i] = longint'(t.tgt[i]) - eye[i];
        up[i]  = longint'(t.upw[i]);
      end
      unit_vec(fwd, f);
      sr[0] = f[1] * up[2] - f[2] * up[1];
      sr[1] = f[2] * up[0] - f[0] * up[2];
      sr[2] = f[0] * up[1] - f[1] * up[0];
      unit_vec(sr, s);
      b.w[3] = word_t'(round_q30(s[1] * f[2] - s[2] * f[1]));
      b.w[4] = word_t'(round_q30(s[2] * f[0] - s[0] * f[2]));
      b.w[5] = word_t'(round_q30(s[0] * f[1] - s[1] * f[0]));
      for (int i = 0; i < 3; i++) begin
        sh = -eye[i];
        if (sh > 64'sd2147483647) sh = 64'sd2147483647;
        b.w[i]     = word_t'(s[i]);
        b.w[6 + i] = word_t'(-f[i]);
        b.w[9 + i] = word_t'(sh);
      end
      return b;
    endfunction

    function void note_input(view_in_t t);
      expected_q.push_back(view_basis(t));
    endfunction

    function void check_result(basis_t got);
      basis_t exp_b;
      bit     bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction");
        return;
      end
      exp_b = expected_q.pop_front();
      checked++;
      bad = 0;
      for (int i = 0; i < NUM_OUT; i++) begin
        if (got.w[i] !== exp_b.w[i]) begin
          bad = 1;
          if (mismatches < 10)
            $display("ERROR: result %0d %s expected %h got %h", checked, names[i],
                     exp_b.w[i], got.w[i]);
        end
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  logic  done_o;
  word_t eye_i[3];
  word_t tgt_i[3];
  word_t upw_i[3];
  word_t res_o[NUM_OUT];
  logic  busy_q;
  int    cycles;
  int    sent;

  basis_scoreboard sb;

  look_at_view_matrix dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .eye_x_i    (eye_i[0]),
    .eye_y_i    (eye_i[1]),
    .eye_z_i    (eye_i[2]),
    .target_x_i (tgt_i[0]),
    .target_y_i (tgt_i[1]),
    .target_z_i (tgt_i[2]),
    .upward_x_i (upw_i[0]),
    .upward_y_i (upw_i[1]),
    .upward_z_i (upw_i[2]),
    .done_o     (done_o),
    .side_x_o   (res_o[0]),
    .side_y_o   (res_o[1]),
    .side_z_o   (res_o[2]),
    .true_up_x_o(res_o[3]),
    .true_up_y_o(res_o[4]),
    .true_up_z_o(res_o[5]),
    .back_x_o   (res_o[6]),
    .back_y_o   (res_o[7]),
    .back_z_o   (res_o[8]),
    .shift_x_o  (res_o[9]),
    .shift_y_o  (res_o[10]),
    .shift_z_o  (res_o[11])
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    busy_q <= busy_o;
  end

  always @(posedge clk_i) begin
    view_in_t t;
    basis_t   r;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        t.eye = eye_i;
        t.tgt = tgt_i;
        t.upw = upw_i;
        sb.note_input(t);
      end
      if (done_o) begin
        for (int i = 0; i < NUM_OUT; i++) r.w[i] = res_o[i];
        sb.check_result(r);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 8 << 16)) - (4 << 16);
      2: return word_t'($urandom_range(0, 255)) - 128;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic view_in_t rand_item();
    view_in_t t;
    int       mode;
    int       k;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      t.eye[i] = rand_word(mode);
      t.tgt[i] = rand_word(mode);
      t.upw[i] = rand_word($urandom_range(0, 3));
    end
    case ($urandom_range(0, 9))
      0: t.tgt = t.eye;
      1: t.upw = '{0, 0, 0};
      2: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) t.upw[i] = word_t'((t.tgt[i] - t.eye[i]) * k);
        for (int i = 0; i < 3; i++) t.tgt[i] = t.eye[i] + (t.upw[i] / k);
      end
      3: t.eye[$urandom_range(0, 2)] = 32'sh80000000;
      default: ;
    endcase
    return t;
  endfunction

  task automatic send(view_in_t t, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    eye_i   <= t.eye;
    tgt_i   <= t.tgt;
    upw_i   <= t.upw;
    do @(posedge clk_i); while (busy_q);
    sent++;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic view_in_t mk(word_t e[3], word_t g[3], word_t u[3]);
    view_in_t t;
    t.eye = e;
    t.tgt = g;
    t.upw = u;
    return t;
  endfunction

  initial begin
    view_in_t dir_q[$];
    word_t    mx;
    word_t    mn;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    sb = new();
    cycles  = 0;
    sent    = 0;
    busy_q  = 1'b0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    eye_i   = '{0, 0, 0};
    tgt_i   = '{0, 0, 0};
    upw_i   = '{0, 0, 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_q.push_back(mk('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
    dir_q.push_back(mk('{0, 0, 65536}, '{0, 0, 0}, '{0, 65536, 0}));
    dir_q.push_back(mk('{5, 6, 7}, '{5, 6, 7}, '{0, 65536, 0}));
    dir_q.push_back(mk('{0, 0, 0}, '{0, 0, -65536}, '{0, 0, 0}));
    dir_q.push_back(mk('{0, 0, 0}, '{0, 0, -65536}, '{0, 0, 131072}));
    dir_q.push_back(mk('{mn, mn, mn}, '{mx, mx, mx}, '{mx, mn, 0}));
    dir_q.push_back(mk('{mx, mx, mx}, '{mn, mn, mn}, '{mn, mx, 1}));
    dir_q.push_back(mk('{mn, 0, mx}, '{mx, 1, mn}, '{mn, mn, mx}));
    dir_q.push_back(mk('{-1, -1, -1}, '{0, 0, 0}, '{1, -1, 1}));
    dir_q.push_back(mk('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}));
    dir_q.push_back(mk('{0, 0, 0}, '{1, 1, 1}, '{mx, mx, mx}));
    dir_q.push_back(mk('{mn, 1, -1}, '{0, 0, 0}, '{0, 0, 65536}));
    dir_q.push_back(mk('{32'sh55555555, 32'shAAAAAAAA, 0}, '{32'shAAAAAAAA, 32'sh55555555, 0},
                       '{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F}));
    dir_q.push_back(mk('{3 << 16, 2 << 16, 1 << 16}, '{0, 0, 0}, '{0, 1 << 16, 0}));
    foreach (dir_q[i]) send(dir_q[i], 1'b0);

    // hold off until the pipeline is empty
    start_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    for (int n = 0; n < NUM_ITEMS; n++) begin
      send(rand_item(), n < NUM_ITEMS - 150);
      if (n == NUM_ITEMS / 2) begin
        start_i <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d view transactions, checked %0d results", sent, sb.checked);
    $display("covered extreme coordinates, coincident eye and target, degenerate up");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("mismatches: %0d, missing results: %0d", sb.mismatches, sb.expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
